>>> design/tls_pkg.sv
// Shared types and constants for the telnet line sanitiser.
`default_nettype none
package tls_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } tls_in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic [8:0] spaces_before;
    logic       has_char;
    logic       line_end;
  } tls_out_t;

  localparam logic [7:0] B_IAC   = 8'hFF;
  localparam logic [7:0] B_SE    = 8'hF0;
  localparam logic [7:0] B_SB    = 8'hFA;
  localparam logic [7:0] B_WILL  = 8'hFB;
  localparam logic [7:0] B_DONT  = 8'hFE;
  localparam logic [7:0] B_SPACE = 8'h20;
  localparam logic [7:0] B_DEL   = 8'h7F;
  localparam logic [7:0] B_TAB   = 8'h09;

  localparam logic [2:0] MODE_TEXT    = 3'd0;
  localparam logic [2:0] MODE_CMD     = 3'd1;
  localparam logic [2:0] MODE_OPT     = 3'd2;
  localparam logic [2:0] MODE_SUB     = 3'd3;
  localparam logic [2:0] MODE_SUB_IAC = 3'd4;

  localparam int unsigned SPACE_W = 9;

endpackage
`default_nettype wire

>>> design/telnet_line_sanitiser.sv
// Top level of the telnet line sanitiser: input register, parser, result register.
// Strips telnet commands, option negotiation and subnegotiation from a received
// line, turns tabs into spaces, drops non-printable bytes and trims leading and
// trailing spaces; inner spaces are reported as a saturated count carried with
// the next character. One byte per clock cycle is taken while the input is not
// stalled. An accepted byte passes through the input register and then, when it
// yields a result, into the result register that drives the output. The input
// stalls only while a pending result cannot move into a held output register.
`default_nettype none
module telnet_line_sanitiser #(
  parameter int unsigned MAX_LINE_BYTES = 512
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  tls_pkg::tls_in_t  in_data_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output tls_pkg::tls_out_t out_data_o
);
  import tls_pkg::*;

  logic     s1_valid_q;
  tls_in_t  s1_data_q;
  logic     out_valid_q;
  tls_out_t out_data_q;

  logic     emit;
  tls_out_t res;
  logic     out_free;
  logic     s1_fire;
  logic     in_take;

  tls_parse #(
    .MAX_LINE_BYTES(MAX_LINE_BYTES)
  ) u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (s1_data_q),
    .adv_i  (s1_fire),
    .emit_o (emit),
    .res_o  (res)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && (!emit || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) s1_valid_q <= 1'b1;
      else if (s1_fire) s1_valid_q <= 1'b0;
      if (s1_fire && emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) s1_data_q <= in_data_i;
    if (s1_fire && emit) out_data_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

>>> design/tls_parse.sv
// Telnet mode machine, held-space counter and per-byte result logic.
`default_nettype none
module tls_parse #(
  parameter int unsigned MAX_LINE_BYTES = 512
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  tls_pkg::tls_in_t item_i,
  input  wire              adv_i,
  output logic             emit_o,
  output tls_pkg::tls_out_t res_o
);
  import tls_pkg::*;

  localparam int unsigned CapRaw = (MAX_LINE_BYTES - 1 < 511) ? (MAX_LINE_BYTES - 1) : 511;
  localparam logic [SPACE_W-1:0] SpaceCap = SPACE_W'(CapRaw);

  logic [2:0]         mode_q, mode_d;
  logic [SPACE_W-1:0] held_q, held_d;
  logic               started_q, started_d;
  logic               has_char;
  logic [7:0]         b;

  assign b = item_i.in_byte;

  always_comb begin
    mode_d    = mode_q;
    held_d    = held_q;
    started_d = started_q;
    has_char  = 1'b0;
    case (mode_q)
      MODE_CMD: begin
        if (b == B_SB) mode_d = MODE_SUB;
        else if (b >= B_WILL && b <= B_DONT) mode_d = MODE_OPT;
        else mode_d = MODE_TEXT;
      end
      MODE_OPT: mode_d = MODE_TEXT;
      MODE_SUB: begin
        if (b == B_IAC) mode_d = MODE_SUB_IAC;
      end
      MODE_SUB_IAC: begin
        if (b == B_SE) mode_d = MODE_TEXT;
        else if (b != B_IAC) mode_d = MODE_SUB;
      end
      default: begin
        mode_d = MODE_TEXT;
        if (b == B_IAC) begin
          mode_d = MODE_CMD;
        end else if (b == B_TAB || b == B_SPACE) begin
          if (started_q && held_q < SpaceCap) held_d = held_q + SPACE_W'(1);
        end else if (b > B_SPACE && b < B_DEL) begin
          has_char  = 1'b1;
          held_d    = '0;
          started_d = 1'b1;
        end
      end
    endcase
    if (item_i.in_last) begin
      mode_d    = MODE_TEXT;
      held_d    = '0;
      started_d = 1'b0;
    end
  end

  assign emit_o              = has_char | item_i.in_last;
  assign res_o.out_char      = has_char ? b[6:0] : 7'd0;
  assign res_o.spaces_before = has_char ? held_q : '0;
  assign res_o.has_char      = has_char;
  assign res_o.line_end      = item_i.in_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_TEXT;
      held_q    <= '0;
      started_q <= 1'b0;
    end else if (adv_i) begin
      mode_q    <= mode_d;
      held_q    <= held_d;
      started_q <= started_d;
    end
  end

endmodule
`default_nettype wire

>>> test/tb_telnet_line_sanitiser.sv
// Testbench for telnet_line_sanitiser: queued line stimulus, clocked driver and monitor.
`default_nettype none
module tb_telnet_line_sanitiser;
  import tls_pkg::*;

  localparam int unsigned LINE_BYTES = 512;
  localparam logic [8:0] SPACE_CAP = (LINE_BYTES - 1 < 511) ? 9'(LINE_BYTES - 1) : 9'd511;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 160;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  tls_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  tls_out_t out_data_o;

  telnet_line_sanitiser #(.MAX_LINE_BYTES(LINE_BYTES)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  tls_in_t     pending_bytes[$];
  tls_out_t    expected_results[$];
  logic [7:0]  line_buf[$];
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          in_took = 1'b0;

  // predictor state
  logic [2:0] parse_mode = MODE_TEXT;
  logic [8:0] held_spaces = '0;
  logic       text_started = 1'b0;

  function automatic bit sanitise_byte(input tls_in_t item, output tls_out_t res);
    logic [7:0] b;
    bit emit;
    b = item.in_byte;
    emit = 1'b0;
    res = '0;
    case (parse_mode)
      MODE_CMD: begin
        if (b == B_SB) parse_mode = MODE_SUB;
        else if (b >= B_WILL && b <= B_DONT) parse_mode = MODE_OPT;
        else parse_mode = MODE_TEXT;
      end
      MODE_OPT: parse_mode = MODE_TEXT;
      MODE_SUB: begin
        if (b == B_IAC) parse_mode = MODE_SUB_IAC;
      end
      MODE_SUB_IAC: begin
        if (b == B_SE) parse_mode = MODE_TEXT;
        else if (b != B_IAC) parse_mode = MODE_SUB;
      end
      default: begin
        parse_mode = MODE_TEXT;
        if (b == B_IAC) begin
          parse_mode = MODE_CMD;
        end else if (b == B_TAB || b == B_SPACE) begin
          if (text_started && held_spaces < SPACE_CAP) held_spaces = held_spaces + 9'd1;
        end else if (b > B_SPACE && b < B_DEL) begin
          emit = 1'b1;
          res.out_char = b[6:0];
          res.spaces_before = held_spaces;
          held_spaces = '0;
          text_started = 1'b1;
        end
      end
    endcase
    res.has_char = emit;
    res.line_end = item.in_last;
    if (item.in_last) begin
      parse_mode = MODE_TEXT;
      held_spaces = '0;
      text_started = 1'b0;
    end
    return emit || item.in_last;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    line_buf = {line_buf, b};
  endtask

  task automatic end_line();
    tls_in_t item;
    foreach (line_buf[i]) begin
      item.in_byte = line_buf[i];
      item.in_last = (i == line_buf.size() - 1);
      pending_bytes = {pending_bytes, item};
    end
    items_queued += line_buf.size();
    line_buf.delete();
  endtask

  task automatic add_chunk(input bit allow_open_sub);
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 19);
    if (kind <= 6) begin
      put_byte(8'($urandom_range(8'h21, 8'h7E)));
    end else if (kind <= 9) begin
      n = $urandom_range(1, 4);
      repeat (n) put_byte($urandom_range(0, 1) ? B_SPACE : B_TAB);
    end else if (kind <= 11) begin
      put_byte(B_IAC);
      put_byte(8'($urandom_range(0, 255)));
    end else if (kind <= 13) begin
      put_byte(B_IAC);
      put_byte(8'($urandom_range(B_WILL, B_DONT)));
      put_byte(8'($urandom_range(0, 255)));
    end else if (kind <= 15) begin
      put_byte(B_IAC);
      put_byte(B_SB);
      n = $urandom_range(0, 4);
      repeat (n) put_byte($urandom_range(0, 3) == 0 ? B_IAC : 8'($urandom_range(0, 255)));
      if (!allow_open_sub || $urandom_range(0, 4) != 0) begin
        put_byte(B_IAC);
        put_byte(B_SE);
      end
    end else begin
      put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic add_random_line();
    int unsigned n;
    n = $urandom_range(1, 7);
    for (int unsigned i = 0; i < n; i++) add_chunk(i == n - 1);
    end_line();
  endtask

  task automatic add_long_space_line();
    put_byte(8'h78);
    repeat ($urandom_range(515, 560)) put_byte($urandom_range(0, 3) ? B_SPACE : B_TAB);
    put_byte(8'h79);
    put_byte(8'($urandom_range(0, 255)));
    end_line();
  endtask

  task automatic wait_drained();
    while (items_taken != items_queued || expected_results.size() != 0) @(negedge clk_i);
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      if (!in_valid_i || in_took) begin
        in_took = 1'b0;
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data_i <= pending_bytes.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    tls_out_t want;
    tls_out_t res;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("telnet_line_sanitiser verification failed");
      $finish;
    end else if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        in_took = 1'b1;
        items_taken++;
        if (sanitise_byte(in_data_i, res)) expected_results = {expected_results, res};
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction %p", out_data_o));
        end else begin
          want = expected_results.pop_front();
          if (out_data_o.out_char !== want.out_char)
            report_mismatch($sformatf("out_char %h, want %h", out_data_o.out_char,
                                      want.out_char));
          if (out_data_o.spaces_before !== want.spaces_before)
            report_mismatch($sformatf("spaces_before %0d, want %0d",
                                      out_data_o.spaces_before, want.spaces_before));
          if (out_data_o.has_char !== want.has_char)
            report_mismatch($sformatf("has_char %b, want %b", out_data_o.has_char,
                                      want.has_char));
          if (out_data_o.line_end !== want.line_end)
            report_mismatch($sformatf("line_end %b, want %b", out_data_o.line_end,
                                      want.line_end));
        end
      end
    end
  end

  initial begin
    int unsigned mark;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // trimming and tabs
    line_buf = '{B_SPACE, B_TAB, 8'h41, B_SPACE, B_TAB, 8'h7E, B_SPACE};
    end_line();
    // option, doubled IAC, DEL, subnegotiation with IAC IAC SE, NUL, lone IAC at end
    line_buf = '{B_IAC, B_WILL, 8'h01, B_IAC, B_IAC, B_DEL, B_IAC, B_SB, 8'h80,
                 B_IAC, B_IAC, B_SE, 8'h5A, 8'h00, B_IAC};
    end_line();
    // unclosed subnegotiation
    line_buf = '{B_IAC, B_SB, 8'h41};
    end_line();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      if (p == 0) add_long_space_line();
      mark = items_queued;
      while (items_queued - mark < PHASE_ITEMS) add_random_line();
      wait_drained();
    end

    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("telnet_line_sanitiser verification clean");
    end else begin
      $display("telnet_line_sanitiser verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
